/* hdl/ray_triangle_intersect_defines.svh */
// Assertion macros shared by the ray/triangle block
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RTI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ray/triangle implication check failed");

// Next-cycle implication, checked outside reset
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ray/triangle next-cycle check failed");

`endif

/* hdl/rti_pkg.sv */
package rti_pkg;

  // coordinate format and derived exact widths
  localparam int COORD_W   = 32;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int CROSS_W   = 2 * COORD_W + 3;
  localparam int SPLIT_W   = COORD_W + 2;
  localparam int SCALAR_W  = 3 * SPLIT_W;
  localparam int QUO_W     = COORD_W + 2;
  localparam int EPS_W     = 32;
  localparam int CFG_IDX_W = 2;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR_X,
    CFG_DIR_Y,
    CFG_DIR_Z,
    CFG_DET_EPS
  } rti_cfg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
    logic signed [COORD_W-1:0] orig_x;
    logic signed [COORD_W-1:0] orig_y;
    logic signed [COORD_W-1:0] orig_z;
  } rti_in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] ray_param;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
  } rti_out_t;

endpackage

/* hdl/rti_div.sv */
module rti_div #(
  parameter int NumW = 126,
  parameter int DenW = 102,
  parameter int QuoW = 34
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW:0]   quo_o,
  output logic            ovf_o
);

  localparam int RemW = DenW + QuoW;
  localparam int XW   = ((NumW > RemW) ? NumW : RemW) + 1;

  logic [RemW-1:0] rem_q [QuoW+1];
  logic [DenW-1:0] den_q [QuoW+1];
  logic [QuoW-1:0] quo_q [QuoW+1];
  logic            ovf_q [QuoW+1];
  logic [RemW:0]   trial [1:QuoW];
  logic            ovf_in;
  logic            rnd;

  // quotient too large for the result range
  assign ovf_in = XW'(num_i) >= (XW'(den_i) << QuoW);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ovf_in ? '0 : RemW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= ovf_in;
    end
  end

  // one restoring step per stage, most significant quotient bit first
  for (genvar i = 1; i <= QuoW; i++) begin : g_step
    assign trial[i] = (RemW+1)'(rem_q[i-1]) - ((RemW+1)'(den_q[i-1]) << (QuoW - i));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= trial[i][RemW] ? rem_q[i-1] : trial[i][RemW-1:0];
        den_q[i] <= den_q[i-1];
        quo_q[i] <= {quo_q[i-1][QuoW-2:0], ~trial[i][RemW]};
        ovf_q[i] <= ovf_q[i-1];
      end
    end
  end

  // round to nearest, ties away from zero
  assign rnd = {rem_q[QuoW], 1'b0} >= (RemW+1)'(den_q[QuoW]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= (QuoW+1)'(quo_q[QuoW]) + (QuoW+1)'(rnd);
      ovf_o <= ovf_q[QuoW];
    end
  end

endmodule

/* hdl/ray_triangle_intersect.sv */
// Path: an accepted input word passes the arithmetic stages, the divider registers and the output register.
// Throughput: one word per cycle; the whole pipeline advances together, so it holds only
// while the output side takes words (a stall while a word waits at the output freezes every stage).
// Division stages: one restoring quotient bit per stage, 34 stages per divider.
// Reset: asynchronous, active low; clears all valid bits, direction to (0, 0, 1.0) and
// det_epsilon to 42950. No clearing pass.
`include "ray_triangle_intersect_defines.svh"

module ray_triangle_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  rti_pkg::rti_in_t                            in_data_i,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output rti_pkg::rti_out_t                           out_data_o,
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [rti_pkg::CFG_IDX_W-1:0]               cfg_index_i,
  input  logic [rti_pkg::COORD_W-1:0]                 cfg_data_i
);

  import rti_pkg::*;

  localparam int LOW_W  = EDGE_W + SPLIT_W + 1;
  localparam int HIGH_W = EDGE_W + CROSS_W - SPLIT_W;
  localparam int DIFF_W = SCALAR_W + 2;
  localparam int CMP_W  = (((SCALAR_W + 32) > (EPS_W + 3 * FRAC_BITS)) ?
                           (SCALAR_W + 32) : (EPS_W + 3 * FRAC_BITS)) + 1;
  localparam int NLO_W  = SPLIT_W + 1 + COORD_W;
  localparam int ND_W   = SCALAR_W + COORD_W;
  localparam int TN_W   = SCALAR_W + FRAC_BITS;
  localparam int DIV_L  = QUO_W + 2;
  localparam int SUM_W  = QUO_W + 3;
  localparam int NSTG   = 8;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef struct packed {
    logic                      vld;
    logic                      hit;
    logic [3:0]                neg;
    logic signed [COORD_W-1:0] o_x;
    logic signed [COORD_W-1:0] o_y;
    logic signed [COORD_W-1:0] o_z;
  } side_t;

  // ---------------------------------------------------------------- control
  logic              en;
  logic              out_valid_q;
  logic [NSTG:1]     v_q;
  rti_out_t          out_q;
  rti_out_t          out_d;

  assign en          = ~out_valid_q | ~out_stall_i;
  assign in_stall_o  = ~en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------- config words
  logic signed [COORD_W-1:0] dir_q [3];
  logic [EPS_W-1:0]          eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= COORD_W'(1) << FRAC_BITS;
      eps_q    <= EPS_W'(42950);
    end else if (cfg_valid_i) begin
      unique case (rti_cfg_e'(cfg_index_i))
        CFG_DIR_X:   dir_q[0] <= cfg_data_i;
        CFG_DIR_Y:   dir_q[1] <= cfg_data_i;
        CFG_DIR_Z:   dir_q[2] <= cfg_data_i;
        CFG_DET_EPS: eps_q    <= cfg_data_i[EPS_W-1:0];
        default:     eps_q    <= eps_q;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-1:1], in_valid_i};
    end
  end

  // origin rides alongside the arithmetic stages
  logic signed [COORD_W-1:0] o_pipe_q [1:NSTG][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_pipe_q[1][0] <= in_data_i.orig_x;
      o_pipe_q[1][1] <= in_data_i.orig_y;
      o_pipe_q[1][2] <= in_data_i.orig_z;
      for (int n = 2; n <= NSTG; n++) begin
        o_pipe_q[n] <= o_pipe_q[n-1];
      end
    end
  end

  // ------------------------------------------------------ stage 1: edges
  logic signed [EDGE_W-1:0] s1_e1_q [3];
  logic signed [EDGE_W-1:0] s1_e2_q [3];
  logic signed [EDGE_W-1:0] s1_s_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_e1_q[0] <= EDGE_W'(in_data_i.v1_x) - EDGE_W'(in_data_i.v0_x);
      s1_e1_q[1] <= EDGE_W'(in_data_i.v1_y) - EDGE_W'(in_data_i.v0_y);
      s1_e1_q[2] <= EDGE_W'(in_data_i.v1_z) - EDGE_W'(in_data_i.v0_z);
      s1_e2_q[0] <= EDGE_W'(in_data_i.v2_x) - EDGE_W'(in_data_i.v0_x);
      s1_e2_q[1] <= EDGE_W'(in_data_i.v2_y) - EDGE_W'(in_data_i.v0_y);
      s1_e2_q[2] <= EDGE_W'(in_data_i.v2_z) - EDGE_W'(in_data_i.v0_z);
      s1_s_q[0]  <= EDGE_W'(in_data_i.orig_x) - EDGE_W'(in_data_i.v0_x);
      s1_s_q[1]  <= EDGE_W'(in_data_i.orig_y) - EDGE_W'(in_data_i.v0_y);
      s1_s_q[2]  <= EDGE_W'(in_data_i.orig_z) - EDGE_W'(in_data_i.v0_z);
    end
  end

  // ------------------------------------- stage 2: cross product terms
  logic signed [2*EDGE_W-1:0] s2_pq_q [6];
  logic signed [2*EDGE_W-1:0] s2_pr_q [6];
  logic signed [EDGE_W-1:0]   s2_e1_q [3];
  logic signed [EDGE_W-1:0]   s2_e2_q [3];
  logic signed [EDGE_W-1:0]   s2_s_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      // q = d x e2
      s2_pq_q[0] <= dir_q[1] * s1_e2_q[2];
      s2_pq_q[1] <= dir_q[2] * s1_e2_q[1];
      s2_pq_q[2] <= dir_q[2] * s1_e2_q[0];
      s2_pq_q[3] <= dir_q[0] * s1_e2_q[2];
      s2_pq_q[4] <= dir_q[0] * s1_e2_q[1];
      s2_pq_q[5] <= dir_q[1] * s1_e2_q[0];
      // r = s x e1
      s2_pr_q[0] <= s1_s_q[1] * s1_e1_q[2];
      s2_pr_q[1] <= s1_s_q[2] * s1_e1_q[1];
      s2_pr_q[2] <= s1_s_q[2] * s1_e1_q[0];
      s2_pr_q[3] <= s1_s_q[0] * s1_e1_q[2];
      s2_pr_q[4] <= s1_s_q[0] * s1_e1_q[1];
      s2_pr_q[5] <= s1_s_q[1] * s1_e1_q[0];
      s2_e1_q    <= s1_e1_q;
      s2_e2_q    <= s1_e2_q;
      s2_s_q     <= s1_s_q;
    end
  end

  // --------------------------------------- stage 3: cross products q, r
  logic signed [CROSS_W-1:0] s3_q_q  [3];
  logic signed [CROSS_W-1:0] s3_r_q  [3];
  logic signed [EDGE_W-1:0]  s3_e1_q [3];
  logic signed [EDGE_W-1:0]  s3_e2_q [3];
  logic signed [EDGE_W-1:0]  s3_s_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s3_q_q[k] <= CROSS_W'(s2_pq_q[2*k]) - CROSS_W'(s2_pq_q[2*k+1]);
        s3_r_q[k] <= CROSS_W'(s2_pr_q[2*k]) - CROSS_W'(s2_pr_q[2*k+1]);
      end
      s3_e1_q <= s2_e1_q;
      s3_e2_q <= s2_e2_q;
      s3_s_q  <= s2_s_q;
    end
  end

  // ----------------------- stage 4: dot product terms as split partials
  // dot 0: a = e1.q, dot 1: Nu = s.q, dot 2: Nv = d.r, dot 3: Nt = e2.r
  logic signed [EDGE_W-1:0]  op_x [4][3];
  logic signed [CROSS_W-1:0] op_y [4][3];
  logic signed [LOW_W-1:0]   s4_lo_q [4][3];
  logic signed [HIGH_W-1:0]  s4_hi_q [4][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      op_x[0][k] = s3_e1_q[k];
      op_y[0][k] = s3_q_q[k];
      op_x[1][k] = s3_s_q[k];
      op_y[1][k] = s3_q_q[k];
      op_x[2][k] = EDGE_W'(dir_q[k]);
      op_y[2][k] = s3_r_q[k];
      op_x[3][k] = s3_e2_q[k];
      op_y[3][k] = s3_r_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          s4_lo_q[j][k] <= op_x[j][k] * $signed({1'b0, op_y[j][k][SPLIT_W-1:0]});
          s4_hi_q[j][k] <= op_x[j][k] * $signed(op_y[j][k][CROSS_W-1:SPLIT_W]);
        end
      end
    end
  end

  // ------------------------------------------ stage 5: join the partials
  logic signed [SCALAR_W-1:0] s5_p_q [4][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          s5_p_q[j][k] <= SCALAR_W'(s4_lo_q[j][k]) + (SCALAR_W'(s4_hi_q[j][k]) <<< SPLIT_W);
        end
      end
    end
  end

  // --------------------------------------------- stage 6: dot products
  logic signed [SCALAR_W-1:0] s6_dot_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s6_dot_q[j] <= s5_p_q[j][0] + s5_p_q[j][1] + s5_p_q[j][2];
      end
    end
  end

  // ------------------------- stage 7: miss tests, Nt*d partial products
  logic [SCALAR_W-1:0]       abs_a;
  logic signed [DIFF_W-1:0]  diff;
  logic                      a_neg;
  logic                      miss_par;
  logic                      miss_u;
  logic                      miss_v;
  logic                      miss_uv;
  logic                      s7_hit_q;
  logic                      s7_aneg_q;
  logic [SCALAR_W-1:0]       s7_absa_q;
  logic signed [SCALAR_W-1:0] s7_nt_q;
  logic signed [NLO_W-1:0]   s7_pn_q [3][3];

  assign a_neg    = s6_dot_q[0][SCALAR_W-1];
  assign abs_a    = a_neg ? SCALAR_W'(-s6_dot_q[0]) : SCALAR_W'(s6_dot_q[0]);
  assign diff     = DIFF_W'(s6_dot_q[1]) + DIFF_W'(s6_dot_q[2]) - DIFF_W'(s6_dot_q[0]);
  // parallel: zero determinant, or |a| below epsilon
  assign miss_par = (s6_dot_q[0] == '0) ||
                    ((CMP_W'(abs_a) << 32) < (CMP_W'(eps_q) << (3 * FRAC_BITS)));
  assign miss_u   = (s6_dot_q[1] != '0) && (s6_dot_q[1][SCALAR_W-1] != a_neg);
  assign miss_v   = (s6_dot_q[2] != '0) && (s6_dot_q[2][SCALAR_W-1] != a_neg);
  assign miss_uv  = (diff != '0) && (diff[DIFF_W-1] == a_neg);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_hit_q  <= ~(miss_par | miss_u | miss_v | miss_uv);
      s7_aneg_q <= a_neg;
      s7_absa_q <= abs_a;
      s7_nt_q   <= s6_dot_q[3];
      for (int k = 0; k < 3; k++) begin
        s7_pn_q[k][0] <= $signed({1'b0, s6_dot_q[3][SPLIT_W-1:0]}) * dir_q[k];
        s7_pn_q[k][1] <= $signed({1'b0, s6_dot_q[3][2*SPLIT_W-1:SPLIT_W]}) * dir_q[k];
        s7_pn_q[k][2] <= $signed(s6_dot_q[3][SCALAR_W-1:2*SPLIT_W]) * dir_q[k];
      end
    end
  end

  // ------------------------------- stage 8: numerator magnitudes, signs
  logic signed [ND_W-1:0] ntd [3];
  logic                   nt_neg;
  logic [SCALAR_W-1:0]    abs_nt;
  logic                   s8_hit_q;
  logic [3:0]             s8_neg_q;
  logic [SCALAR_W-1:0]    s8_den_q;
  logic [TN_W-1:0]        s8_tnum_q;
  logic [ND_W-1:0]        s8_dnum_q [3];

  assign nt_neg = s7_nt_q[SCALAR_W-1];
  assign abs_nt = nt_neg ? SCALAR_W'(-s7_nt_q) : SCALAR_W'(s7_nt_q);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ntd[k] = ND_W'(s7_pn_q[k][0]) + (ND_W'(s7_pn_q[k][1]) <<< SPLIT_W) +
               (ND_W'(s7_pn_q[k][2]) <<< (2 * SPLIT_W));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_hit_q    <= s7_hit_q;
      s8_den_q    <= s7_absa_q;
      s8_tnum_q   <= TN_W'(abs_nt) << FRAC_BITS;
      s8_neg_q[0] <= nt_neg ^ s7_aneg_q;
      for (int k = 0; k < 3; k++) begin
        s8_dnum_q[k]  <= ntd[k][ND_W-1] ? ND_W'(-ntd[k]) : ND_W'(ntd[k]);
        s8_neg_q[k+1] <= ntd[k][ND_W-1] ^ s7_aneg_q;
      end
    end
  end

  // ---------------------------------------------------------- dividers
  logic [QUO_W:0] quo [4];
  logic           ovf [4];

  rti_div #(
    .NumW (TN_W),
    .DenW (SCALAR_W),
    .QuoW (QUO_W)
  ) u_div_t (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s8_tnum_q),
    .den_i (s8_den_q),
    .quo_o (quo[0]),
    .ovf_o (ovf[0])
  );

  for (genvar k = 0; k < 3; k++) begin : g_div_pt
    rti_div #(
      .NumW (ND_W),
      .DenW (SCALAR_W),
      .QuoW (QUO_W)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s8_dnum_q[k]),
      .den_i (s8_den_q),
      .quo_o (quo[k+1]),
      .ovf_o (ovf[k+1])
    );
  end

  // side data matched to the divider latency
  side_t side_q [DIV_L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < DIV_L; n++) begin
        side_q[n] <= '0;
      end
    end else if (en) begin
      side_q[0].vld <= v_q[NSTG];
      side_q[0].hit <= s8_hit_q;
      side_q[0].neg <= s8_neg_q;
      side_q[0].o_x <= o_pipe_q[NSTG][0];
      side_q[0].o_y <= o_pipe_q[NSTG][1];
      side_q[0].o_z <= o_pipe_q[NSTG][2];
      for (int n = 1; n < DIV_L; n++) begin
        side_q[n] <= side_q[n-1];
      end
    end
  end

  // ------------------------------------- output: sign, offset, saturate
  side_t                     last;
  logic signed [SUM_W-1:0]   base [4];
  logic signed [SUM_W-1:0]   sval [4];
  logic signed [SUM_W-1:0]   sum  [4];
  logic signed [COORD_W-1:0] res  [4];

  assign last = side_q[DIV_L-1];

  always_comb begin
    base[0] = '0;
    base[1] = SUM_W'(last.o_x);
    base[2] = SUM_W'(last.o_y);
    base[3] = SUM_W'(last.o_z);
    for (int j = 0; j < 4; j++) begin
      sval[j] = last.neg[j] ? -SUM_W'(quo[j]) : SUM_W'(quo[j]);
      sum[j]  = base[j] + sval[j];
      if (!last.hit) begin
        res[j] = '0;
      end else if (ovf[j]) begin
        res[j] = last.neg[j] ? COORD_W'(SAT_LO) : COORD_W'(SAT_HI);
      end else if (sum[j] > SAT_HI) begin
        res[j] = COORD_W'(SAT_HI);
      end else if (sum[j] < SAT_LO) begin
        res[j] = COORD_W'(SAT_LO);
      end else begin
        res[j] = COORD_W'(sum[j]);
      end
    end
    out_d.hit       = last.hit;
    out_d.ray_param = res[0];
    out_d.hit_x     = res[1];
    out_d.hit_y     = res[2];
    out_d.hit_z     = res[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------- checks
  `RTI_ASSERT_IMP(a_miss_is_zero, out_valid_o && !out_data_o.hit, out_data_o[4*COORD_W-1:0] == '0)
  `RTI_ASSERT_IMP(a_stall_needs_word, in_stall_o, out_valid_o && out_stall_i)
  `RTI_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, v_q[1])

endmodule

/* tb/rti_checker.sv */
`timescale 1ns / 1ps

// Watches the data and config channels, predicts each result word and compares it
module rti_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  rti_pkg::rti_in_t              in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  rti_pkg::rti_out_t             out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rti_pkg::COORD_W-1:0]   cfg_data_i,
  output int                            err_cnt_o,
  output int                            pending_o,
  output int                            hit_cnt_o,
  output int                            miss_cnt_o
);

  import rti_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam int FRAC_W = 16;

  // local copy of the register file
  logic signed [COORD_W-1:0] ray_dir [3];
  logic [EPS_W-1:0]          eps_thr;
  rti_out_t                  expected_q [$];

  function automatic wide_t widen(logic [COORD_W-1:0] x);
    return $signed({{(256-COORD_W){x[COORD_W-1]}}, x});
  endfunction

  function automatic wide_t abs_w(wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  // nearest, ties away from zero
  function automatic wide_t div_nearest(wide_t n, wide_t d);
    logic [255:0] nm, dm, q, r;
    nm = abs_w(n);
    dm = abs_w(d);
    q  = nm / dm;
    r  = nm % dm;
    if ((r << 1) >= dm) q = q + 1;
    return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [COORD_W-1:0] clamp(wide_t x);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (COORD_W - 1)) - 1;
    lo = -(wide_t'(1) <<< (COORD_W - 1));
    if (x > hi) return hi[COORD_W-1:0];
    if (x < lo) return lo[COORD_W-1:0];
    return x[COORD_W-1:0];
  endfunction

  function automatic rti_out_t intersect_ray(rti_in_t w);
    wide_t    p0 [3], p1 [3], p2 [3], o [3], d [3], e1 [3], e2 [3], s [3], q [3], r [3];
    wide_t    det, nu, nv, nt, diff;
    rti_out_t res;
    p0 = '{widen(w.v0_x), widen(w.v0_y), widen(w.v0_z)};
    p1 = '{widen(w.v1_x), widen(w.v1_y), widen(w.v1_z)};
    p2 = '{widen(w.v2_x), widen(w.v2_y), widen(w.v2_z)};
    o  = '{widen(w.orig_x), widen(w.orig_y), widen(w.orig_z)};
    res = '0;
    for (int k = 0; k < 3; k++) begin
      d[k]  = widen(ray_dir[k]);
      e1[k] = p1[k] - p0[k];
      e2[k] = p2[k] - p0[k];
      s[k]  = o[k] - p0[k];
    end
    q[0] = d[1] * e2[2] - d[2] * e2[1];
    q[1] = d[2] * e2[0] - d[0] * e2[2];
    q[2] = d[0] * e2[1] - d[1] * e2[0];
    det = e1[0] * q[0] + e1[1] * q[1] + e1[2] * q[2];
    // parallel ray
    if (det == 0) return res;
    if (abs_w(det) < ($signed({224'b0, eps_thr}) <<< FRAC_W)) return res;
    nu = s[0] * q[0] + s[1] * q[1] + s[2] * q[2];
    if (nu != 0 && ((nu < 0) != (det < 0))) return res;
    r[0] = s[1] * e1[2] - s[2] * e1[1];
    r[1] = s[2] * e1[0] - s[0] * e1[2];
    r[2] = s[0] * e1[1] - s[1] * e1[0];
    nv = d[0] * r[0] + d[1] * r[1] + d[2] * r[2];
    if (nv != 0 && ((nv < 0) != (det < 0))) return res;
    diff = nu + nv - det;
    if (diff != 0 && ((diff < 0) == (det < 0))) return res;
    nt = e2[0] * r[0] + e2[1] * r[1] + e2[2] * r[2];
    res.hit       = 1'b1;
    res.ray_param = clamp(div_nearest(nt <<< FRAC_W, det));
    res.hit_x     = clamp(o[0] + div_nearest(nt * d[0], det));
    res.hit_y     = clamp(o[1] + div_nearest(nt * d[1], det));
    res.hit_z     = clamp(o[2] + div_nearest(nt * d[2], det));
    return res;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    rti_out_t exp_w;
    if (!rst_ni) begin
      ray_dir[0] <= '0;
      ray_dir[1] <= '0;
      ray_dir[2] <= 32'sd65536;
      eps_thr    <= 32'd42950;
      err_cnt_o  <= 0;
      hit_cnt_o  <= 0;
      miss_cnt_o <= 0;
      expected_q.delete();
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (rti_cfg_e'(cfg_index_i))
          CFG_DIR_X:   ray_dir[0] <= cfg_data_i;
          CFG_DIR_Y:   ray_dir[1] <= cfg_data_i;
          CFG_DIR_Z:   ray_dir[2] <= cfg_data_i;
          CFG_DET_EPS: eps_thr    <= cfg_data_i;
          default: ;
        endcase
      end
      // result side
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          if (err_cnt_o < 10)
            $display("ERROR: result word with nothing expected: %p", out_data_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_w = expected_q.pop_front();
          if (exp_w.hit) hit_cnt_o <= hit_cnt_o + 1;
          else miss_cnt_o <= miss_cnt_o + 1;
          if (out_data_i.hit !== exp_w.hit || out_data_i.ray_param !== exp_w.ray_param ||
              out_data_i.hit_x !== exp_w.hit_x || out_data_i.hit_y !== exp_w.hit_y ||
              out_data_i.hit_z !== exp_w.hit_z) begin
            if (err_cnt_o < 10)
              $display({"ERROR: mismatch expected hit=%0d t=%0d p=(%0d,%0d,%0d)",
                        " got hit=%0d t=%0d p=(%0d,%0d,%0d)"},
                       exp_w.hit, exp_w.ray_param, exp_w.hit_x, exp_w.hit_y, exp_w.hit_z,
                       out_data_i.hit, out_data_i.ray_param, out_data_i.hit_x,
                       out_data_i.hit_y, out_data_i.hit_z);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      // input side, after the pop so ordering within the queue holds
      if (in_valid_i && !in_stall_i)
        expected_q.insert(expected_q.size(), intersect_ray(in_data_i));
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rti_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  rti_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rti_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;
  int                   err_cnt, pending, hit_cnt, miss_cnt;
  bit                   quiet = 1'b0;
  int                   n_words = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ray_triangle_intersect i_dut (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid),  .in_stall_o (in_stall),  .in_data_i (in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i (cfg_data)
  );

  rti_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid),  .in_stall_i (in_stall),  .in_data_i (in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i (cfg_data),
    .err_cnt_o(err_cnt), .pending_o(pending), .hit_cnt_o(hit_cnt), .miss_cnt_o(miss_cnt)
  );

  // result-side stall bursts
  always @(posedge clk_i) begin
    if (quiet || $urandom_range(0, 3) != 0) begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end else begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  end

  // present one word, hold until taken, then maybe go idle for a burst
  task automatic send_word(rti_in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (in_stall);
    n_words++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(rti_cfg_e idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_ray(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz, logic [31:0] eps);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    write_reg(CFG_DET_EPS, eps);
  endtask

  function automatic logic [31:0] rnd_small(int bits);
    return $signed($urandom) >>> (32 - bits);
  endfunction

  // a triangle roughly around the origin, scale given in bits; often a hit
  function automatic rti_in_t near_tri(int bits);
    rti_in_t w;
    w.v0_x = rnd_small(bits); w.v0_y = rnd_small(bits); w.v0_z = rnd_small(bits);
    w.v1_x = rnd_small(bits); w.v1_y = rnd_small(bits); w.v1_z = rnd_small(bits);
    w.v2_x = rnd_small(bits); w.v2_y = rnd_small(bits); w.v2_z = rnd_small(bits);
    w.orig_x = (w.v0_x + w.v1_x + w.v2_x) / 3 + rnd_small(bits - 2);
    w.orig_y = (w.v0_y + w.v1_y + w.v2_y) / 3 + rnd_small(bits - 2);
    w.orig_z = rnd_small(bits + 2);
    return w;
  endfunction

  function automatic rti_in_t rnd_word();
    rti_in_t w;
    for (int k = 0; k < 12; k++) w[k*32 +: 32] = $urandom;
    return w;
  endfunction

  function automatic rti_in_t mk(int ax, ay, az, bx, by, bz, cx, cy, cz, ox, oy, oz);
    return '{ax, ay, az, bx, by, bz, cx, cy, cz, ox, oy, oz};
  endfunction

  localparam int ONE  = 65536;
  localparam int MAXC = 32'h7fffffff;
  localparam int MINC = 32'h80000000;

  task automatic random_phase(int n, int bits);
    rti_in_t w;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1:    w = rnd_word();
        2:       w = near_tri(30);
        default: w = near_tri(bits);
      endcase
      send_word(w);
    end
  endtask

  // stimulus
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed, reset configuration
    send_word(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/4, ONE/4, -ONE));  // plain hit
    send_word(mk(0, 0, 0, ONE, 0, 0, 2*ONE, 0, 0, 0, 0, 0));           // degenerate, zero det
    send_word(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));           // vertex, u=v=0, behind
    send_word(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/2, ONE/2, 0));     // u+v exactly 1
    send_word(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -1, ONE/4, 0));        // u below 0
    send_word(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/4, -1, 0));        // v below 0
    send_word(mk(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/2, ONE/2 + 1, 0)); // u+v just over 1
    send_word(mk(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0));                 // tiny det, below eps
    send_word(mk(0, 0, MAXC, ONE, 0, MAXC, 0, ONE, MAXC, 1, 1, MINC)); // large t, saturates
    send_word(mk(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC, 0, 0, MAXC));
    send_word(mk(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    send_word(mk(0, 0, 0, 0, ONE, 0, ONE, 0, 0, ONE/4, ONE/4, 0));     // positive det
    send_word('0);
    drain();

    // zero threshold, tilted direction
    set_ray(ONE/3, -ONE/5, ONE, 32'd0);
    send_word(mk(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0));
    send_word(mk(0, 0, 0, ONE, 0, 0, 2*ONE, 0, 0, 0, 0, 0));
    random_phase(120, 20);
    drain();

    // extreme direction, maximum threshold: almost everything parallel
    set_ray(MINC, MAXC, MINC, 32'hffffffff);
    send_word(mk(MINC, MINC, 0, MAXC, MINC, 0, MINC, MAXC, 0, 0, 0, MAXC));
    random_phase(80, 24);
    drain();

    // random direction and threshold
    set_ray(rnd_small(20), rnd_small(20), $urandom_range(ONE/2, 4*ONE), $urandom_range(0, 1 << 20));
    random_phase(140, 22);
    drain();

    // fully random register contents
    set_ray($urandom, $urandom, $urandom, $urandom);
    random_phase(80, 26);
    drain();

    // back to an orthographic view, no idling from here
    set_ray(0, 0, ONE, 32'd42950);
    quiet = 1'b1;
    random_phase(220, 20);
    drain();

    $display("Sent %0d words over six register settings: %0d hits, %0d misses.",
             n_words, hit_cnt, miss_cnt);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Timeout with %0d words outstanding", pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/rti_pkg.sv
hdl/rti_div.sv
hdl/ray_triangle_intersect.sv
tb/rti_checker.sv
tb/tb_top.sv
